### rtl/hsv2rgb_pkg.sv
// ----------------------------------------------------------------------------
// HSV/HSL to RGB package
// Fixed-point constants, widths and the hue sector codes of the converter.
// ----------------------------------------------------------------------------
package hsv2rgb_pkg;

  localparam int unsigned HUE_FRAC_BITS = 6;
  localparam int unsigned CHANNEL_BITS  = 8;

  localparam int unsigned HUE_W  = 15;
  localparam int unsigned CH_W   = CHANNEL_BITS;
  localparam int unsigned FULL_SCALE  = (1 << CHANNEL_BITS) - 1;
  localparam int unsigned SECTOR_SPAN = 60 << HUE_FRAC_BITS;
  localparam int unsigned NUM_SECTORS = 6;

  // Sector fraction, 0 .. SECTOR_SPAN inclusive.
  localparam int unsigned T_W   = 12;
  // s * m product, chroma and offset in units of one sector span.
  localparam int unsigned SM_W  = 2 * CH_W;
  localparam int unsigned CA_W  = SM_W + 1;
  localparam int unsigned A_W   = CA_W + 1;
  // x = 2 * s * m * t.
  localparam int unsigned X_W   = SM_W + T_W + 1;
  // Full-precision channel numerator and its pre-shifted form.
  localparam int unsigned N_W   = 31;
  localparam int unsigned DIV_SHIFT = HUE_FRAC_BITS + 2;
  localparam int unsigned NQ_W  = N_W - DIV_SHIFT;
  // Remaining divisor after the power-of-two part has been shifted out.
  localparam int unsigned DIVISOR = (2 * FULL_SCALE * SECTOR_SPAN) >> DIV_SHIFT;
  localparam int unsigned DIVISOR_W = 13;
  localparam int unsigned RECIP_SHIFT = 32;
  localparam int unsigned RECIP = 32'((64'd1 << RECIP_SHIFT) / 64'(DIVISOR));
  localparam int unsigned RECIP_W = 20;
  localparam int unsigned PROD_W  = NQ_W + RECIP_W;
  localparam int unsigned Q_W     = PROD_W - RECIP_SHIFT;

  typedef enum logic [2:0] {
    SECT_RED_YELLOW   = 3'd0,
    SECT_YELLOW_GREEN = 3'd1,
    SECT_GREEN_CYAN   = 3'd2,
    SECT_CYAN_BLUE    = 3'd3,
    SECT_BLUE_MAGENTA = 3'd4,
    SECT_MAGENTA_RED  = 3'd5
  } sector_e;

  // Which term each channel adds on top of the offset.
  typedef struct packed {
    logic add_chroma;
    logic add_x;
  } ch_sel_t;

endpackage

### rtl/hsv_hsl_to_rgb_core.sv
// ----------------------------------------------------------------------------
// HSV/HSL to RGB converter core
// Six-stage pipeline turning one hue/saturation/level pixel into RGB per clock.
// ----------------------------------------------------------------------------
// Usage:
//   A request is taken at a rising edge where start is high and busy is low.
//   busy is always low, so a new pixel may be presented in every cycle.
//   Each result appears on red_o, green_o, blue_o and opacity_o for exactly
//   one cycle with strobe_o high, once its request has passed the six
//   register stages: sector split, s*m multiply, x multiply, channel numerator,
//   reciprocal multiply, correction and clamp. Throughput is one pixel per
//   clock. The receiver cannot stall the block: results are never held back.
//   color_mode is written through cfg_we_i/cfg_wdata_i (0 = HSV, 1 = HSL);
//   the user must write it only while no request is in flight, which the block
//   does not enforce. Each request captures the mode it enters with. Reset
//   clears the mode to HSV and empties the pipeline, so no strobe is raised
//   until a new request has gone through.
// ----------------------------------------------------------------------------
module hsv_hsl_to_rgb_core
  import hsv2rgb_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             cfg_we_i,
  input  logic             cfg_wdata_i,
  input  logic             start,
  output logic             busy,
  input  logic [HUE_W-1:0] hue_i,
  input  logic             hue_undefined_i,
  input  logic [CH_W-1:0]  saturation_i,
  input  logic [CH_W-1:0]  level_i,
  input  logic [CH_W-1:0]  alpha_i,
  output logic             strobe_o,
  output logic [CH_W-1:0]  red_o,
  output logic [CH_W-1:0]  green_o,
  output logic [CH_W-1:0]  blue_o,
  output logic [CH_W-1:0]  opacity_o
);

  logic mode_q;
  logic accept;

  assign busy   = 1'b0;
  assign accept = start && !busy;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= 1'b0;
    end else if (cfg_we_i) begin
      mode_q <= cfg_wdata_i;
    end
  end

  // Valid bits of the six stages.
  logic [5:0] vld_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= {vld_q[4:0], accept};
    end
  end

  // ---------------------------------------------------------------- stage 1
  sector_e         s1_sector_d, s1_sector_q;
  logic [T_W-1:0]  s1_t_d, s1_t_q;
  logic            s1_gray_d, s1_gray_q;
  logic [CH_W-1:0] s1_m_d, s1_m_q;
  logic [CH_W-1:0] s1_sat_q, s1_lvl_q, s1_alpha_q;
  logic            s1_mode_q;

  always_comb begin
    logic [2:0]       sec;
    logic [HUE_W-1:0] base;
    logic [HUE_W-1:0] frac;
    logic [CH_W:0]    twice;
    logic [CH_W:0]    lvl_dev;
    sec  = 3'd0;
    base = '0;
    for (int k = 1; k < NUM_SECTORS; k++) begin
      if (hue_i >= HUE_W'(k * SECTOR_SPAN)) begin
        sec  = 3'(k);
        base = HUE_W'(k * SECTOR_SPAN);
      end
    end
    frac = hue_i - base;
    s1_sector_d = sector_e'(sec);
    // Even sectors rise with the fraction, odd sectors fall.
    if (sec[0]) begin
      s1_t_d = T_W'(SECTOR_SPAN) - frac[T_W-1:0];
    end else begin
      s1_t_d = frac[T_W-1:0];
    end
    s1_gray_d = hue_undefined_i || (hue_i >= HUE_W'(NUM_SECTORS * SECTOR_SPAN));

    // HSL chroma scales with 1 - |2l - 1|, here FULL - |2l - FULL|.
    twice = {level_i, 1'b0};
    if (twice >= (CH_W+1)'(FULL_SCALE)) begin
      lvl_dev = twice - (CH_W+1)'(FULL_SCALE);
    end else begin
      lvl_dev = (CH_W+1)'(FULL_SCALE) - twice;
    end
    if (mode_q) begin
      s1_m_d = CH_W'((CH_W+1)'(FULL_SCALE) - lvl_dev);
    end else begin
      s1_m_d = level_i;
    end
  end

  always_ff @(posedge clk_i) begin
    s1_sector_q <= s1_sector_d;
    s1_t_q      <= s1_t_d;
    s1_gray_q   <= s1_gray_d;
    s1_m_q      <= s1_m_d;
    s1_sat_q    <= saturation_i;
    s1_lvl_q    <= level_i;
    s1_alpha_q  <= alpha_i;
    s1_mode_q   <= mode_q;
  end

  // ---------------------------------------------------------------- stage 2
  logic [SM_W-1:0] s2_sm_q;
  sector_e         s2_sector_q;
  logic [T_W-1:0]  s2_t_q;
  logic            s2_gray_q, s2_mode_q;
  logic [CH_W-1:0] s2_lvl_q, s2_alpha_q;

  always_ff @(posedge clk_i) begin
    s2_sm_q     <= SM_W'(s1_sat_q) * SM_W'(s1_m_q);
    s2_sector_q <= s1_sector_q;
    s2_t_q      <= s1_t_q;
    s2_gray_q   <= s1_gray_q;
    s2_mode_q   <= s1_mode_q;
    s2_lvl_q    <= s1_lvl_q;
    s2_alpha_q  <= s1_alpha_q;
  end

  // ---------------------------------------------------------------- stage 3
  // Quantities are in units of one sector span except x, which is exact.
  logic [X_W-1:0]  s3_x_d, s3_x_q;
  logic [CA_W-1:0] s3_chroma_d, s3_chroma_q;
  logic [CA_W-1:0] s3_off_d, s3_off_q;
  sector_e         s3_sector_q;
  logic            s3_gray_q;
  logic [CH_W-1:0] s3_alpha_q;

  always_comb begin
    logic [CA_W-1:0]    lv2f;
    logic [CA_W-1:0]    sub;
    logic [X_W-2:0]     smt;
    smt         = (X_W-1)'(s2_sm_q) * (X_W-1)'(s2_t_q);
    s3_x_d      = {smt, 1'b0};
    s3_chroma_d = {1'b0, s2_sm_q} << 1;
    lv2f        = CA_W'(s2_lvl_q) * CA_W'(2 * FULL_SCALE);
    // HSV offset is v - c, HSL offset is l - c/2.
    sub = s2_mode_q ? CA_W'(s2_sm_q) : s3_chroma_d;
    s3_off_d = (lv2f >= sub) ? (lv2f - sub) : '0;
  end

  always_ff @(posedge clk_i) begin
    s3_x_q      <= s3_x_d;
    s3_chroma_q <= s3_chroma_d;
    s3_off_q    <= s3_off_d;
    s3_sector_q <= s2_sector_q;
    s3_gray_q   <= s2_gray_q;
    s3_alpha_q  <= s2_alpha_q;
  end

  // ---------------------------------------------------------------- stage 4
  ch_sel_t         sel_r, sel_g, sel_b;
  logic [NQ_W-1:0] s4_n_d [3];
  logic [NQ_W-1:0] s4_n_q [3];
  logic [CH_W-1:0] s4_alpha_q;

  always_comb begin
    sel_r = '0;
    sel_g = '0;
    sel_b = '0;
    if (!s3_gray_q) begin
      case (s3_sector_q)
        SECT_RED_YELLOW:   begin sel_r.add_chroma = 1'b1; sel_g.add_x = 1'b1; end
        SECT_YELLOW_GREEN: begin sel_r.add_x = 1'b1; sel_g.add_chroma = 1'b1; end
        SECT_GREEN_CYAN:   begin sel_g.add_chroma = 1'b1; sel_b.add_x = 1'b1; end
        SECT_CYAN_BLUE:    begin sel_g.add_x = 1'b1; sel_b.add_chroma = 1'b1; end
        SECT_BLUE_MAGENTA: begin sel_r.add_x = 1'b1; sel_b.add_chroma = 1'b1; end
        default:           begin sel_r.add_chroma = 1'b1; sel_b.add_x = 1'b1; end
      endcase
    end
  end

  // Numerator q + FULL*F of round half up, with the power-of-two part of the
  // divisor already shifted out (the floor survives the split).
  function automatic logic [NQ_W-1:0] numer(input ch_sel_t sel,
                                            input logic [CA_W-1:0] off,
                                            input logic [CA_W-1:0] chroma,
                                            input logic [X_W-1:0] x);
    logic [A_W-1:0] a;
    logic [N_W-1:0] n;
    a = A_W'(off) + (sel.add_chroma ? A_W'(chroma) : '0) + A_W'(FULL_SCALE);
    n = N_W'(a) * N_W'(SECTOR_SPAN) + (sel.add_x ? N_W'(x) : '0);
    return n[N_W-1:DIV_SHIFT];
  endfunction

  always_comb begin
    s4_n_d[0] = numer(sel_r, s3_off_q, s3_chroma_q, s3_x_q);
    s4_n_d[1] = numer(sel_g, s3_off_q, s3_chroma_q, s3_x_q);
    s4_n_d[2] = numer(sel_b, s3_off_q, s3_chroma_q, s3_x_q);
  end

  always_ff @(posedge clk_i) begin
    s4_n_q     <= s4_n_d;
    s4_alpha_q <= s3_alpha_q;
  end

  // ---------------------------------------------------------------- stage 5
  // Reciprocal estimate: equal to the quotient or one below it.
  logic [Q_W-1:0]  s5_q0_q [3];
  logic [NQ_W-1:0] s5_n_q  [3];
  logic [CH_W-1:0] s5_alpha_q;

  always_ff @(posedge clk_i) begin
    for (int c = 0; c < 3; c++) begin
      logic [PROD_W-1:0] prod;
      prod = PROD_W'(s4_n_q[c]) * PROD_W'(RECIP);
      s5_q0_q[c] <= prod[PROD_W-1:RECIP_SHIFT];
      s5_n_q[c]  <= s4_n_q[c];
    end
    s5_alpha_q <= s4_alpha_q;
  end

  // ---------------------------------------------------------------- stage 6
  logic [CH_W-1:0] out_d [3];
  logic [CH_W-1:0] out_q [3];
  logic [CH_W-1:0] out_alpha_q;

  always_comb begin
    for (int c = 0; c < 3; c++) begin
      logic [NQ_W-1:0] qd;
      logic [NQ_W-1:0] rem;
      logic [Q_W-1:0]  quo;
      qd  = NQ_W'(s5_q0_q[c]) * NQ_W'(DIVISOR);
      rem = s5_n_q[c] - qd;
      quo = s5_q0_q[c] + ((rem >= NQ_W'(DIVISOR)) ? Q_W'(1) : Q_W'(0));
      out_d[c] = (quo > Q_W'(FULL_SCALE)) ? CH_W'(FULL_SCALE) : quo[CH_W-1:0];
    end
  end

  always_ff @(posedge clk_i) begin
    out_q       <= out_d;
    out_alpha_q <= s5_alpha_q;
  end

  assign strobe_o  = vld_q[5];
  assign red_o     = out_q[0];
  assign green_o   = out_q[1];
  assign blue_o    = out_q[2];
  assign opacity_o = out_alpha_q;

  // ------------------------------------------------------------ assertions
  a_req_gives_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |-> ##6 strobe_o)
    else $error("request did not produce a result after six cycles");

  a_result_has_req: assert property (@(posedge clk_i) disable iff (!rst_ni)
    strobe_o |-> $past(accept, 6))
    else $error("result strobe without a matching request");

  a_alpha_passes: assert property (@(posedge clk_i) disable iff (!rst_ni)
    strobe_o |-> (opacity_o == $past(alpha_i, 6)))
    else $error("opacity does not match the alpha of its request");

  a_undef_is_gray: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (strobe_o && $past(hue_undefined_i, 6)) |-> (red_o == green_o && green_o == blue_o))
    else $error("undefined hue did not give a gray result");

endmodule
